>>> src/plms_pkg.sv
// shared types and constants of the packet latency matcher
package plms_pkg;

    localparam int INDEX_BITS = 16;
    localparam int ID_W       = 32;
    localparam int TS_W       = 64;
    localparam int CNT_W      = 32;
    localparam int OUT_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 232;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_MATCH  = 1'b1;

    localparam logic signed [TS_W-1:0] Q_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [TS_W-1:0] Q_MIN = -64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] stamp;
    } t_entry;

    // access to the slot table
    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [INDEX_BITS-1:0] addr;
        t_entry                wr_data;
    } t_tbl_req;

endpackage

>>> src/packet_latency_matcher_stats_unit.sv
// top level: packet latency matcher with running mean and variance
// Matches record and match beats by packet id through a 2^16-slot table and keeps
// hit/miss counts and running latency statistics. After reset the table is swept
// to zero, one slot a cycle, during which no input beat is taken (the threshold
// register can still be written). A record beat or a miss goes from evaluation
// straight to the output state. A hit also goes through the mean step, the
// M2 product and the variance, which the first hit skips. These take two passes
// through the shared one-bit-per-cycle divider (mean step and variance) and one
// through the partial-product multiplier. The result sits in an output register,
// so the next beat is accepted while it waits.
module packet_latency_matcher_stats_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // threshold register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [plms_pkg::TS_W-1:0]          i_cfg_data,
    // input beats
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [plms_pkg::IN_DATA_W-1:0]     i_s_tdata,  // packet_id, time_stamp
    input  logic [0:0]                         i_s_tuser,  // opcode
    // result beats
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // latency, below_threshold, hits_total, misses_total, mean_latency,
    // latency_var, zero pad
    output logic [plms_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic [0:0]                         o_m_tuser   // hit
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_EVAL   = 10'b00_0000_0010,
        S_DELTA  = 10'b00_0000_0100,
        S_MDIV   = 10'b00_0000_1000,
        S_MEAN   = 10'b00_0001_0000,
        S_MUL    = 10'b00_0010_0000,
        S_VSTART = 10'b00_0100_0000,
        S_VDIV   = 10'b00_1000_0000,
        S_OUT    = 10'b01_0000_0000,
        S_SPARE  = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [plms_pkg::TS_W-1:0]   r_thresh;
    logic                        r_op;
    logic [plms_pkg::ID_W-1:0]   r_pid;
    logic [plms_pkg::TS_W-1:0]   r_ts;
    logic                        r_hit;
    logic [plms_pkg::TS_W-1:0]   r_lat;
    logic                        r_below;
    logic [plms_pkg::TS_W-1:0]   r_x;
    logic [plms_pkg::TS_W-1:0]   r_delta;
    logic [plms_pkg::TS_W-1:0]   r_mean;
    logic [plms_pkg::TS_W-1:0]   r_m2;
    logic [plms_pkg::CNT_W-1:0]  r_hits;
    logic [plms_pkg::CNT_W-1:0]  r_misses;
    logic [plms_pkg::OUT_W-1:0]  r_var;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [plms_pkg::OUT_DATA_W-1:0] r_out_data;

    plms_pkg::t_tbl_req tbl_req;
    plms_pkg::t_entry   tbl_rd;
    logic               clearing;

    logic                        accept;
    logic                        is_hit;
    logic [plms_pkg::TS_W-1:0]   lat;
    logic signed [plms_pkg::TS_W-1:0] lat_sat;
    logic [plms_pkg::TS_W-1:0]   delta;
    logic [plms_pkg::TS_W-1:0]   delta2;
    logic [plms_pkg::TS_W-1:0]   mean_new;
    logic                        div_start;
    logic [plms_pkg::TS_W-1:0]   div_dividend;
    logic [plms_pkg::CNT_W-1:0]  div_divisor;
    logic                        div_done;
    logic [plms_pkg::TS_W-1:0]   div_quot;
    logic                        mul_start;
    logic                        mul_done;
    logic [2*plms_pkg::TS_W-1:0] mul_prod;
    logic [plms_pkg::TS_W-1:0]   prod_sat;
    logic [plms_pkg::TS_W:0]     m2_sum;
    logic [plms_pkg::TS_W-1:0]   var_q;
    logic [plms_pkg::TS_W-1:0]   mean_mag;
    logic [plms_pkg::OUT_W-1:0]  mean_int;
    logic                        out_load;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE) && !clearing;
    assign accept      = i_s_tvalid && o_s_tready;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    // table access: read on accept, write back on evaluation
    always_comb begin
        tbl_req.rd_en         = accept;
        tbl_req.wr_en         = (r_state == S_EVAL);
        tbl_req.addr          = accept ? i_s_tdata[plms_pkg::INDEX_BITS-1:0]
                                       : r_pid[plms_pkg::INDEX_BITS-1:0];
        tbl_req.wr_data.id    = (r_op == plms_pkg::OP_RECORD) ? r_pid : '0;
        tbl_req.wr_data.stamp = (r_op == plms_pkg::OP_RECORD) ? r_ts : '0;
    end

    plms_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (tbl_req),
        .o_rd_data  (tbl_rd),
        .o_clearing (clearing)
    );

    // hit check and latency into Q47.16
    assign is_hit = (r_op == plms_pkg::OP_MATCH) && (tbl_rd.id == r_pid)
                    && (tbl_rd.stamp != '0);
    assign lat    = r_ts - tbl_rd.stamp;
    always_comb begin
        if ($signed(lat) > plms_pkg::Q_MAX) begin
            lat_sat = plms_pkg::Q_MAX;
        end else if ($signed(lat) < plms_pkg::Q_MIN) begin
            lat_sat = plms_pkg::Q_MIN;
        end else begin
            lat_sat = $signed(lat);
        end
    end

    // mean and M2 datapath
    assign delta    = r_x - r_mean;
    assign mean_new = r_delta[plms_pkg::TS_W-1] ? (r_mean - div_quot) : (r_mean + div_quot);
    assign delta2   = r_x - r_mean;
    assign prod_sat = (mul_prod[127:80] != '0) ? '1 : mul_prod[79:16];
    assign m2_sum   = {1'b0, r_m2} + {1'b0, prod_sat};
    assign var_q    = {16'b0, div_quot[63:16]};

    // shared divider inputs
    always_comb begin
        div_start    = (r_state == S_DELTA) || (r_state == S_VSTART);
        if (r_state == S_DELTA) begin
            div_dividend = delta[plms_pkg::TS_W-1] ? (64'd0 - delta) : delta;
            div_divisor  = r_hits;
        end else begin
            div_dividend = r_m2;
            div_divisor  = r_hits - 1'b1;
        end
    end

    plms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign mul_start = (r_state == S_MEAN);

    plms_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_delta[plms_pkg::TS_W-1] ? (64'd0 - r_delta) : r_delta),
        .i_b     (delta2[plms_pkg::TS_W-1] ? (64'd0 - delta2) : delta2),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = is_hit ? S_DELTA : S_OUT;
            end
            S_DELTA: begin
                n_state = S_MDIV;
            end
            S_MDIV: begin
                if (div_done) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = (r_hits >= 32'd2) ? S_VSTART : S_OUT;
                end
            end
            S_VSTART: begin
                n_state = S_VDIV;
            end
            S_VDIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
            r_mean   <= '0;
            r_m2     <= '0;
            r_var    <= '0;
        end else begin
            case (r_state)
                S_EVAL: begin
                    if (is_hit) begin
                        if (r_hits != '1) begin
                            r_hits <= r_hits + 1'b1;
                        end
                    end else if (r_op == plms_pkg::OP_MATCH) begin
                        r_misses <= r_misses + 1'b1;
                    end
                end
                S_MDIV: begin
                    if (div_done) begin
                        r_mean <= mean_new;
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        r_m2 <= m2_sum[plms_pkg::TS_W] ? '1 : m2_sum[plms_pkg::TS_W-1:0];
                        if (r_hits < 32'd2) begin
                            r_var <= '0;
                        end
                    end
                end
                S_VDIV: begin
                    if (div_done) begin
                        r_var <= (var_q[63:48] != '0) ? '1 : var_q[47:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // per beat working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_s_tuser[0];
            r_pid <= i_s_tdata[31:0];
            r_ts  <= i_s_tdata[95:32];
        end
        if (r_state == S_EVAL) begin
            r_hit   <= is_hit;
            r_lat   <= is_hit ? lat : '0;
            r_below <= is_hit && ($signed(lat) < $signed(r_thresh));
            r_x     <= {lat_sat[47:0], 16'b0};
        end
        if (r_state == S_DELTA) begin
            r_delta <= delta;
        end
    end

    // mean truncated toward zero
    assign mean_mag = r_mean[plms_pkg::TS_W-1] ? (64'd0 - r_mean) : r_mean;
    assign mean_int = r_mean[plms_pkg::TS_W-1] ? (48'd0 - mean_mag[63:16]) : mean_mag[63:16];

    // output register
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_hit  <= r_hit;
            r_out_data <= {7'b0, r_var, mean_int, r_misses, r_hits, r_below, r_lat};
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_hit;

endmodule

>>> src/plms_table.sv
// slot table memory with clearing sweep after reset
module plms_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plms_pkg::t_tbl_req  i_req,
    output plms_pkg::t_entry    o_rd_data,
    output logic                o_clearing
);

    plms_pkg::t_entry mem [0:(1 << plms_pkg::INDEX_BITS)-1];
    plms_pkg::t_entry r_rd_data;
    logic [plms_pkg::INDEX_BITS-1:0] r_clr_addr;
    logic r_clearing;

    // sweep every slot to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

>>> src/plms_div.sv
// iterative unsigned divider, one quotient bit per cycle
module plms_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [plms_pkg::TS_W-1:0]    i_dividend,
    input  logic [plms_pkg::CNT_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [plms_pkg::TS_W-1:0]    o_quot
);

    logic [plms_pkg::TS_W-1:0]  r_q;
    logic [plms_pkg::CNT_W-1:0] r_rem;
    logic [plms_pkg::CNT_W-1:0] r_div;
    logic [6:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [plms_pkg::CNT_W:0]   trial;
    logic                       fits;

    // shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_q[plms_pkg::TS_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= trial[plms_pkg::CNT_W-1:0] - r_div;
            end else begin
                r_rem <= trial[plms_pkg::CNT_W-1:0];
            end
            r_q <= {r_q[plms_pkg::TS_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> src/plms_mul.sv
// 64 by 64 multiplier from four 32 by 32 partial products
module plms_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [plms_pkg::TS_W-1:0]   i_a,
    input  logic [plms_pkg::TS_W-1:0]   i_b,
    output logic                        o_done,
    output logic [2*plms_pkg::TS_W-1:0] o_prod
);

    logic [plms_pkg::TS_W-1:0]   r_a;
    logic [plms_pkg::TS_W-1:0]   r_b;
    logic [2*plms_pkg::TS_W-1:0] r_acc;
    logic [plms_pkg::TS_W-1:0]   r_pp;
    logic [1:0]                  r_pos;
    logic                        r_pv;
    logic [2:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [31:0]                 a_half;
    logic [31:0]                 b_half;
    logic [6:0]                  shamt;

    assign a_half = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_half = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign shamt  = {{1'b0, r_pos[1]} + {1'b0, r_pos[0]}, 5'b0};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_pv   <= 1'b0;
            end else if (r_busy) begin
                r_pv <= !r_cnt[2];
                if (!r_cnt[2]) begin
                    r_cnt <= r_cnt + 1'b1;
                end else if (r_pv) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one partial product a cycle, accumulated the cycle after
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (!r_cnt[2]) begin
                r_pp  <= a_half * b_half;
                r_pos <= r_cnt[1:0];
            end
            if (r_pv) begin
                r_acc <= r_acc + ({64'b0, r_pp} << shamt);
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> tb/sv/packet_latency_matcher_stats_unit_tb.sv
// testbench of the packet latency matcher: driver, monitor and statistics predictor
module packet_latency_matcher_stats_unit_tb;

    localparam int WDOG_MAX  = 200000;
    localparam int HOLD_LEN  = 4000;
    localparam int DRAIN_CYC = 300;

    typedef struct {
        logic                      op;
        logic [plms_pkg::ID_W-1:0] id;
        logic [plms_pkg::TS_W-1:0] ts;
    } t_pkt;

    typedef struct {
        logic                       hit;
        logic [plms_pkg::TS_W-1:0]  lat;
        logic                       below;
        logic [plms_pkg::CNT_W-1:0] hits;
        logic [plms_pkg::CNT_W-1:0] misses;
        logic [plms_pkg::OUT_W-1:0] mean;
        logic [plms_pkg::OUT_W-1:0] var_q;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [plms_pkg::TS_W-1:0] i_cfg_data = '0;
    logic o_cfg_ready;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [plms_pkg::IN_DATA_W-1:0] i_s_tdata = '0;
    logic [0:0] i_s_tuser = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [plms_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic [0:0] o_m_tuser;

    packet_latency_matcher_stats_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [plms_pkg::ID_W-1:0]  id_tab [int];
    logic [plms_pkg::TS_W-1:0]  stamp_tab [int];
    logic [plms_pkg::CNT_W-1:0] hit_cnt = '0;
    logic [plms_pkg::CNT_W-1:0] miss_cnt = '0;
    logic [plms_pkg::TS_W-1:0]  mean_q = '0;
    logic [plms_pkg::TS_W-1:0]  m2_q = '0;
    logic [plms_pkg::TS_W-1:0]  thresh = '0;

    t_pkt pending_pkts[$];
    t_res expected_results[$];
    int   fail_cnt = 0;
    int   stall_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both, 4 long hold
    bit   s_taken = 1'b0;
    int   idle_cyc = 0;

    function automatic logic [plms_pkg::TS_W-1:0] mag64(logic [plms_pkg::TS_W-1:0] v);
        return v[plms_pkg::TS_W-1] ? -v : v;
    endfunction

    // welford step on one saturated latency
    function automatic void stats_update(logic [plms_pkg::TS_W-1:0] lat);
        logic [plms_pkg::TS_W-1:0] x, delta, delta2, q, prod;
        logic [127:0] full;
        if ($signed(lat) > plms_pkg::Q_MAX) lat = plms_pkg::Q_MAX;
        if ($signed(lat) < plms_pkg::Q_MIN) lat = plms_pkg::Q_MIN;
        x = lat << plms_pkg::FRAC_W;
        if (hit_cnt != '1) hit_cnt = hit_cnt + 1'b1;
        delta = x - mean_q;
        q = mag64(delta) / {32'd0, hit_cnt};
        mean_q = mean_q + (delta[plms_pkg::TS_W-1] ? -q : q);
        delta2 = x - mean_q;
        full = {64'd0, mag64(delta)} * {64'd0, mag64(delta2)};
        full = full >> plms_pkg::FRAC_W;
        prod = (full[127:64] != '0) ? '1 : full[63:0];
        m2_q = (m2_q > ~prod) ? '1 : m2_q + prod;
    endfunction

    // expected result of one accepted packet beat
    function automatic void predict_result(t_pkt p);
        t_res r;
        int slot;
        logic [plms_pkg::TS_W-1:0] old, mi, vq;
        slot = int'(p.id[plms_pkg::INDEX_BITS-1:0]);
        r.hit = 1'b0; r.lat = '0; r.below = 1'b0;
        if (!id_tab.exists(slot)) begin
            id_tab[slot] = '0; stamp_tab[slot] = '0;
        end
        if (p.op == plms_pkg::OP_RECORD) begin
            id_tab[slot] = p.id; stamp_tab[slot] = p.ts;
        end else begin
            old = (id_tab[slot] == p.id) ? stamp_tab[slot] : '0;
            id_tab[slot] = '0; stamp_tab[slot] = '0;
            if (old != '0) begin
                r.hit = 1'b1;
                r.lat = p.ts - old;
                r.below = $signed(r.lat) < $signed(thresh);
                stats_update(r.lat);
            end else begin
                miss_cnt = miss_cnt + 1'b1;
            end
        end
        mi = mag64(mean_q) >> plms_pkg::FRAC_W;
        if (mean_q[plms_pkg::TS_W-1]) mi = -mi;
        vq = '0;
        if (hit_cnt >= 32'd2) begin
            vq = (m2_q / ({32'd0, hit_cnt} - 64'd1)) >> plms_pkg::FRAC_W;
            if (vq > 64'h0000_FFFF_FFFF_FFFF) vq = 64'h0000_FFFF_FFFF_FFFF;
        end
        r.hits = hit_cnt; r.misses = miss_cnt;
        r.mean = mi[plms_pkg::OUT_W-1:0]; r.var_q = vq[plms_pkg::OUT_W-1:0];
        expected_results.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [plms_pkg::TS_W-1:0] got,
                                   logic [plms_pkg::TS_W-1:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_cnt++;
    endtask

    // monitor: input acceptance, result check, watchdog
    always @(posedge i_clk) begin
        t_res e;
        t_pkt p;
        bit act;
        bit taken;
        act = 1'b0;
        taken = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                p.op = i_s_tuser[0];
                p.id = i_s_tdata[31:0];
                p.ts = i_s_tdata[95:32];
                predict_result(p);
                taken = 1'b1;
                act = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                thresh = i_cfg_data;
                act = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                act = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", o_m_tdata[63:0], '0);
                end else begin
                    e = expected_results.pop_front();
                    if (o_m_tuser[0] !== e.hit)
                        report_mismatch("hit", 64'(o_m_tuser[0]), 64'(e.hit));
                    if (o_m_tdata[63:0] !== e.lat)
                        report_mismatch("latency", o_m_tdata[63:0], e.lat);
                    if (o_m_tdata[64] !== e.below)
                        report_mismatch("below_threshold", 64'(o_m_tdata[64]), 64'(e.below));
                    if (o_m_tdata[96:65] !== e.hits)
                        report_mismatch("hits_total", 64'(o_m_tdata[96:65]), 64'(e.hits));
                    if (o_m_tdata[128:97] !== e.misses)
                        report_mismatch("misses_total", 64'(o_m_tdata[128:97]),
                                        64'(e.misses));
                    if (o_m_tdata[176:129] !== e.mean)
                        report_mismatch("mean_latency", 64'(o_m_tdata[176:129]), 64'(e.mean));
                    if (o_m_tdata[224:177] !== e.var_q)
                        report_mismatch("latency_var", 64'(o_m_tdata[224:177]),
                                        64'(e.var_q));
                end
            end
        end
        s_taken <= taken;
        idle_cyc = act ? 0 : idle_cyc + 1;
        if (idle_cyc >= WDOG_MAX) begin
            $display("watchdog timeout");
            $display("Simulation FAILED");
            $finish;
        end
    end

    // driver: offers the next pending packet beat
    always @(negedge i_clk) begin
        t_pkt p;
        bit gap;
        if (i_rst_n && (!i_s_tvalid || s_taken)) begin
            gap = ((stall_mode == 1) && ($urandom_range(0, 99) < 71)) ||
                  ((stall_mode == 3) && ($urandom_range(0, 99) < 18));
            if (pending_pkts.size() != 0 && !gap) begin
                p = pending_pkts.pop_front();
                i_s_tdata <= {p.ts, p.id};
                i_s_tuser <= p.op;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off in the pressure phase
    always @(negedge i_clk) begin
        int hold_left;
        bit hold_done;
        if (stall_mode == 4 && !hold_done) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                2: i_m_tready <= ($urandom_range(0, 99) >= 71);
                3: i_m_tready <= ($urandom_range(0, 99) >= 18);
                default: i_m_tready <= 1'b1;
            endcase
        end
    end

    task automatic add_pkt(logic op, logic [plms_pkg::ID_W-1:0] id,
                           logic [plms_pkg::TS_W-1:0] ts);
        pending_pkts.push_back('{op: op, id: id, ts: ts});
    endtask

    task automatic write_threshold(logic [plms_pkg::TS_W-1:0] v);
        @(negedge i_clk);
        i_cfg_data = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_pkts.size() != 0 || i_s_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // random well-formed record/match pairs with some noise
    task automatic gen_random(int n);
        t_pkt live[$];
        t_pkt p;
        logic [plms_pkg::TS_W-1:0] lat;
        logic [15:0] id_hi;
        logic [5:0] id_lo;
        int k;
        for (int i = 0; i < n; i++) begin
            k = int'($urandom_range(0, 99));
            if (k < 45 || live.size() == 0) begin
                p.op = plms_pkg::OP_RECORD;
                id_hi = 16'($urandom_range(0, 3));
                id_lo = 6'($urandom_range(0, 63));
                p.id = ($urandom_range(0, 7) == 0) ? $urandom : {id_hi, 10'd0, id_lo};
                case ($urandom_range(0, 19))
                    0: p.ts = '0;
                    1, 2: p.ts = {$urandom, $urandom};
                    default: p.ts = {32'd0, $urandom} + 64'd1;
                endcase
                live.push_back(p);
                pending_pkts.push_back(p);
            end else if (k < 90) begin
                k = int'($urandom_range(0, live.size() - 1));
                p = live[k];
                live.delete(k);
                case ($urandom_range(0, 9))
                    0: lat = {$urandom, $urandom};
                    1: lat = 64'd0 - 64'($urandom_range(0, 1000));
                    default: lat = 64'($urandom_range(0, 100000));
                endcase
                add_pkt(plms_pkg::OP_MATCH, p.id, p.ts + lat);
            end else begin
                add_pkt(plms_pkg::OP_MATCH, $urandom, {$urandom, $urandom});
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, threshold at zero
        stall_mode = 0;
        write_threshold('0);
        add_pkt(plms_pkg::OP_RECORD, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
        add_pkt(plms_pkg::OP_MATCH, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        add_pkt(plms_pkg::OP_MATCH, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF); // slot cleared
        add_pkt(plms_pkg::OP_RECORD, 32'h0000_0001, '0);                     // zero stamp
        add_pkt(plms_pkg::OP_MATCH, 32'h0000_0001, 64'd100);
        add_pkt(plms_pkg::OP_MATCH, 32'h0000_0002, 64'd5);                    // empty slot
        add_pkt(plms_pkg::OP_RECORD, 32'h0001_0003, 64'd10);
        add_pkt(plms_pkg::OP_RECORD, 32'h0002_0003, 64'd20);                  // same slot
        add_pkt(plms_pkg::OP_MATCH, 32'h0001_0003, 64'd30);                   // id differs
        add_pkt(plms_pkg::OP_MATCH, 32'h0002_0003, 64'd50);
        add_pkt(plms_pkg::OP_RECORD, 32'h0000_0000, 64'd1);
        add_pkt(plms_pkg::OP_MATCH, 32'h0000_0000, 64'd0);                    // negative
        add_pkt(plms_pkg::OP_RECORD, 32'hABCD_0004, 64'd1);
        add_pkt(plms_pkg::OP_MATCH, 32'hABCD_0004, 64'h7FFF_FFFF_FFFF_FFFF);  // saturates
        add_pkt(plms_pkg::OP_RECORD, 32'h1234_0005, 64'h8000_0000_0000_0000);
        add_pkt(plms_pkg::OP_MATCH, 32'h1234_0005, 64'd1);                    // huge negative
        add_pkt(plms_pkg::OP_RECORD, 32'h5555_AAAA, 64'h5555_5555_AAAA_AAAA);
        add_pkt(plms_pkg::OP_MATCH, 32'h5555_AAAA, 64'h5555_5555_AAAA_AAAA);  // zero latency
        add_pkt(plms_pkg::OP_RECORD, 32'hAAAA_5555, 64'hAAAA_AAAA_5555_5555);
        add_pkt(plms_pkg::OP_MATCH, 32'hAAAA_5555, 64'hAAAA_AAAA_5555_6000);
        gen_random(300);
        wait_idle();

        stall_mode = 1;
        write_threshold(64'h7FFF_FFFF_FFFF_FFFF);
        gen_random(320);
        wait_idle();

        stall_mode = 2;
        write_threshold(64'h8000_0000_0000_0000);
        gen_random(320);
        wait_idle();

        stall_mode = 3;
        write_threshold(64'd50000);
        gen_random(320);
        wait_idle();

        stall_mode = 4;
        write_threshold({$urandom, $urandom});
        gen_random(320);
        wait_idle();

        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> packet_latency_matcher_stats_unit.f
src/plms_pkg.sv
src/plms_table.sv
src/plms_div.sv
src/plms_mul.sv
src/packet_latency_matcher_stats_unit.sv
tb/sv/packet_latency_matcher_stats_unit_tb.sv
